FILE: sv/slud_pkg.sv
// Shared types and constants for the string literal unescape / UTF-8 decoder.
// Used by the front decoder, the command queue, the result sequencer and the top level.
`default_nettype none

package slud_pkg;

  // Result kinds as they appear on the output tuser field
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned MaxUtf8    = 4;

  // Source characters with a structural meaning
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChLowerX  = 8'h78;
  localparam logic [7:0] ChUpperX  = 8'h58;
  localparam logic [7:0] ChLowerU  = 8'h75;
  localparam logic [7:0] ChUpperU  = 8'h55;

  // UTF-8 framing
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Lead4 = 8'hF0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

  // One decoded input item: data bytes in order, then an optional close/error
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [2:0]                 n_data;
    logic                       has_tail;
    kind_e                      tail_kind;
  } cmd_t;

endpackage : slud_pkg

`default_nettype wire

FILE: sv/slud_front.sv
// Front decoder: accepts source bytes, tracks the escape state, and turns
// each item that yields a result into one queue command. Depends on slud_pkg.
`default_nettype none

module slud_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    ch_i,
  input  wire logic          eos_i,
  input  wire logic          full_i,
  output logic               push_o,
  output slud_pkg::cmd_t     cmd_o
);
  import slud_pkg::*;

  typedef enum logic [2:0] {
    M_PLAIN = 3'd0,
    M_ESC   = 3'd1,
    M_HEX   = 3'd2,
    M_OCT   = 3'd3,
    M_UNI   = 3'd4
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [31:0] accum_q, accum_d;
  logic [3:0]  digits_q, digits_d;
  logic        x_upper_q, x_upper_d;

  logic        accept;
  logic        hex_ok, oct_ok;
  logic [3:0]  hex_d;
  logic [7:0]  hex_tmp;
  logic [31:0] hex_next, oct_next;

  logic        flush_en, plain_en, one_en;
  logic [31:0] flush_val;
  logic [7:0]  one_byte;
  logic [2:0]  fl_n, base;
  logic [MaxResults-1:0][7:0] fl_b;
  logic        tail_en;
  kind_e       tail_kind;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Digit classification
  always_comb begin
    hex_ok  = 1'b1;
    hex_tmp = 8'h00;
    if (ch_i inside {["0":"9"]}) begin
      hex_tmp = ch_i - 8'h30;
    end else if (ch_i inside {["a":"f"]}) begin
      hex_tmp = ch_i - 8'h57;
    end else if (ch_i inside {["A":"F"]}) begin
      hex_tmp = ch_i - 8'h37;
    end else begin
      hex_ok = 1'b0;
    end
    hex_d    = hex_tmp[3:0];
    oct_ok   = ch_i inside {["0":"7"]};
    hex_next = {accum_q[27:0], hex_d};
    oct_next = {accum_q[28:0], ch_i[2:0]};
  end

  // State update and command classification
  always_comb begin
    mode_d    = mode_q;
    accum_d   = accum_q;
    digits_d  = digits_q;
    x_upper_d = x_upper_q;
    flush_en  = 1'b0;
    flush_val = accum_q;
    plain_en  = 1'b0;
    one_en    = 1'b0;
    one_byte  = ch_i;
    tail_en   = 1'b0;
    tail_kind = KIND_ERROR;

    if (eos_i) begin
      flush_en  = (mode_q != M_ESC);
      tail_en   = 1'b1;
      tail_kind = KIND_ERROR;
      mode_d    = M_PLAIN;
      accum_d   = '0;
      digits_d  = '0;
      x_upper_d = 1'b0;
    end else begin
      case (mode_q)
        M_ESC: begin
          mode_d    = M_PLAIN;
          accum_d   = '0;
          digits_d  = '0;
          x_upper_d = 1'b0;
          case (ch_i)
            "n":     begin one_en = 1'b1; one_byte = 8'h0A; end
            "t":     begin one_en = 1'b1; one_byte = 8'h09; end
            "r":     begin one_en = 1'b1; one_byte = 8'h0D; end
            "a":     begin one_en = 1'b1; one_byte = 8'h07; end
            "b":     begin one_en = 1'b1; one_byte = 8'h08; end
            "f":     begin one_en = 1'b1; one_byte = 8'h0C; end
            "v":     begin one_en = 1'b1; one_byte = 8'h0B; end
            default: begin
              if (ch_i == ChLowerX || ch_i == ChUpperX) begin
                mode_d    = M_HEX;
                x_upper_d = (ch_i == ChUpperX);
              end else if (ch_i == ChLowerU || ch_i == ChUpperU) begin
                mode_d   = M_UNI;
                digits_d = (ch_i == ChLowerU) ? 4'd4 : 4'd8;
              end else if (oct_ok) begin
                mode_d   = M_OCT;
                accum_d  = {29'd0, ch_i[2:0]};
                digits_d = 4'd2;
              end else begin
                one_en = 1'b1;
              end
            end
          endcase
        end
        M_HEX: begin
          if (hex_ok) begin
            accum_d  = hex_next;
            digits_d = 4'd1;
          end else begin
            flush_en = 1'b1;
            plain_en = 1'b1;
          end
        end
        M_OCT: begin
          if (oct_ok && digits_q != 4'd0) begin
            accum_d  = oct_next;
            digits_d = digits_q - 4'd1;
            if (digits_q == 4'd1) begin
              flush_en  = 1'b1;
              flush_val = oct_next;
            end
          end else begin
            flush_en = 1'b1;
            plain_en = 1'b1;
          end
        end
        M_UNI: begin
          if (hex_ok && digits_q != 4'd0) begin
            accum_d  = hex_next;
            digits_d = digits_q - 4'd1;
            if (digits_q == 4'd1) begin
              flush_en  = 1'b1;
              flush_val = hex_next;
            end
          end else begin
            flush_en = 1'b1;
            plain_en = 1'b1;
          end
        end
        default: begin
          plain_en = 1'b1;
        end
      endcase

      // Any flush or plain character returns to the plain body state
      if (flush_en || plain_en) begin
        mode_d    = M_PLAIN;
        accum_d   = '0;
        digits_d  = '0;
        x_upper_d = 1'b0;
      end
      if (plain_en) begin
        if (ch_i == ChQuote) begin
          tail_en   = 1'b1;
          tail_kind = KIND_CLOSE;
        end else if (ch_i == ChNewline) begin
          tail_en   = 1'b1;
          tail_kind = KIND_ERROR;
        end else if (ch_i == ChBslash) begin
          mode_d = M_ESC;
        end else begin
          one_en = 1'b1;
        end
      end
    end
  end

  // Bytes emitted by closing an open escape
  always_comb begin
    fl_b = '0;
    fl_n = 3'd0;
    case (mode_q)
      M_HEX: begin
        fl_n = 3'd1;
        if (digits_q != 4'd0) begin
          fl_b[0] = flush_val[7:0];
        end else begin
          fl_b[0] = x_upper_q ? ChUpperX : ChLowerX;
        end
      end
      M_OCT: begin
        fl_n    = 3'd1;
        fl_b[0] = flush_val[7:0];
      end
      M_UNI: begin
        if (flush_val[31:7] == '0) begin
          fl_n    = 3'd1;
          fl_b[0] = flush_val[7:0];
        end else if (flush_val[31:11] == '0) begin
          fl_n    = 3'd2;
          fl_b[0] = Utf8Lead2 | {3'd0, flush_val[10:6]};
          fl_b[1] = Utf8Cont | {2'd0, flush_val[5:0]};
        end else if (flush_val[31:16] == '0) begin
          fl_n    = 3'd3;
          fl_b[0] = Utf8Lead3 | {4'd0, flush_val[15:12]};
          fl_b[1] = Utf8Cont | {2'd0, flush_val[11:6]};
          fl_b[2] = Utf8Cont | {2'd0, flush_val[5:0]};
        end else begin
          fl_n    = 3'(MaxUtf8);
          fl_b[0] = Utf8Lead4 | flush_val[25:18];
          fl_b[1] = Utf8Cont | {2'd0, flush_val[17:12]};
          fl_b[2] = Utf8Cont | {2'd0, flush_val[11:6]};
          fl_b[3] = Utf8Cont | {2'd0, flush_val[5:0]};
        end
      end
      default: begin
        fl_n = 3'd0;
      end
    endcase
  end

  // Assemble the command: flushed bytes, then the single byte, then the tail
  always_comb begin
    base = flush_en ? fl_n : 3'd0;
    for (int i = 0; i < MaxResults; i++) begin
      cmd_o.bytes[i] = (3'(i) < base) ? fl_b[i] : one_byte;
    end
    cmd_o.n_data    = base + {2'd0, one_en};
    cmd_o.has_tail  = tail_en;
    cmd_o.tail_kind = tail_kind;
    push_o = accept && (flush_en || one_en || tail_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_PLAIN;
      accum_q   <= '0;
      digits_q  <= '0;
      x_upper_q <= 1'b0;
    end else if (accept) begin
      mode_q    <= mode_d;
      accum_q   <= accum_d;
      digits_q  <= digits_d;
      x_upper_q <= x_upper_d;
    end
  end

  a_oct_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_OCT |-> (digits_q == 4'd1 || digits_q == 4'd2))
    else $error("octal escape with no digit budget left");

  a_uni_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_UNI |-> digits_q <= 4'd8)
    else $error("universal name digit count out of range");

  a_cmd_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> ({1'b0, cmd_o.n_data} + {3'd0, cmd_o.has_tail} <= 4'(MaxResults)))
    else $error("command carries too many results");

endmodule : slud_front

`default_nettype wire

FILE: sv/slud_fifo.sv
// Short command queue between the front decoder and the result sequencer.
// Depends on slud_pkg for the command type.
`default_nettype none

module slud_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire slud_pkg::cmd_t wdata_i,
  input  wire logic      pop_i,
  output slud_pkg::cmd_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import slud_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("push into a full command queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty command queue");

endmodule : slud_fifo

`default_nettype wire

FILE: sv/slud_back.sv
// Result sequencer: walks the head command one result per cycle, while the
// output is not stalled, into a registered output stage. Depends on slud_pkg.
`default_nettype none

module slud_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire slud_pkg::cmd_t head_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output slud_pkg::kind_e  out_kind_o,
  output logic             out_last_o
);
  import slud_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  kind_e      kind_q, kind_d;
  logic       last_q, last_d;

  logic       advance;
  logic [2:0] total_m1;
  logic       at_last;

  always_comb begin
    total_m1 = head_i.n_data + {2'd0, head_i.has_tail} - 3'd1;
    at_last  = (idx_q == total_m1);
    advance  = !empty_i && (!vld_q || out_ready_i);
    pop_o    = advance && at_last;

    idx_d  = idx_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    kind_d = kind_q;
    last_d = last_q;
    if (advance) begin
      idx_d  = at_last ? 3'd0 : idx_q + 3'd1;
      vld_d  = 1'b1;
      last_d = at_last;
      if (idx_q < head_i.n_data) begin
        byte_d = head_i.bytes[idx_q];
        kind_d = KIND_DATA;
      end else begin
        byte_d = 8'h00;
        kind_d = head_i.tail_kind;
      end
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

  a_tail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && kind_q != KIND_DATA |-> last_q)
    else $error("close or error result not marked last");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == 3'd0)
    else $error("result index left open with no command queued");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q <= total_m1)
    else $error("result index past end of command");

endmodule : slud_back

`default_nettype wire

FILE: sv/string_literal_unescape_utf8_core.sv
// Top level of the string literal unescape / UTF-8 decoder.
// Instantiates slud_front, slud_fifo and slud_back; depends on slud_pkg.
//
//  Port group   Dir  tdata               tuser            tlast
//  s_axis_*     in   [7:0] ch            [0] end_of_source  -
//  m_axis_*     out  [7:0] out_byte      [1:0] kind         last
//
// One source byte is accepted per cycle whenever the command queue has room.
// Each byte yields zero to five results; the sequencer emits one result per
// cycle while the output is not stalled, through the single output register
// that it feeds.
// Reset (asynchronous, active low) returns the decoder to the plain body
// state and empties the queue and output stage.
// A stalled output only fills the queue; input is refused once it is full.
`default_nettype none

module string_literal_unescape_utf8_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // ingress: source bytes
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] ch
  input  wire logic       s_axis_tuser,   // [0] end_of_source
  // egress: decoded results
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]      m_axis_tuser,   // [1:0] kind
  output logic            m_axis_tlast    // last result of the request
);
  import slud_pkg::*;

  cmd_t  push_cmd, head_cmd;
  logic  push, pop, full, empty;
  kind_e out_kind;

  // Decode and classify each request into at most one command
  slud_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .ch_i       (s_axis_tdata),
    .eos_i      (s_axis_tuser),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Hold commands so the front can run ahead of a stalled output
  slud_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  // Advance through the head command one result at a time
  slud_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_kind_o  (out_kind),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;

endmodule : string_literal_unescape_utf8_core

`default_nettype wire

FILE: verif/slud_result_checker.sv
// Result checker for string_literal_unescape_utf8_core: decodes every accepted
// source byte itself and compares the block's results in order.
// Depends on slud_pkg for the result kinds and the character constants.
module slud_result_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       s_axis_tuser,   // [0] end_of_source
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
  input  logic [1:0] m_axis_tuser,   // [1:0] kind
  input  logic       m_axis_tlast,
  output int         fail_count_o,
  output int         pending_o,
  output int         data_count_o,
  output int         close_count_o,
  output int         error_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import slud_pkg::*;

  typedef enum logic [2:0] {
    ST_PLAIN = 3'd0,
    ST_ESC   = 3'd1,
    ST_HEX   = 3'd2,
    ST_OCT   = 3'd3,
    ST_UNI   = 3'd4
  } lit_state_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } result_t;

  lit_state_e  st;
  logic [31:0] acc;
  logic [3:0]  digits_rem;
  logic        xup;

  result_t step_q[$];
  result_t decoded_q[$];
  result_t want;
  int      outstanding;
  int      fails;
  int      n_data, n_close, n_error;

  assign fail_count_o  = fails;
  assign pending_o     = outstanding;
  assign data_count_o  = n_data;
  assign close_count_o = n_close;
  assign error_count_o = n_error;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic clear_lit_state();
    st         = ST_PLAIN;
    acc        = '0;
    digits_rem = '0;
    xup        = 1'b0;
  endtask

  task automatic put_result(logic [7:0] d, kind_e k);
    result_t r;
    r.data = d;
    r.kind = k;
    r.last = 1'b0;
    step_q = {step_q, r};
  endtask

  task automatic put_utf8(logic [31:0] cp);
    if (cp < 32'h80) begin
      put_result(cp[7:0], KIND_DATA);
    end else begin
      if (cp < 32'h800) begin
        put_result(Utf8Lead2 | cp[13:6], KIND_DATA);
      end else if (cp < 32'h10000) begin
        put_result(Utf8Lead3 | cp[19:12], KIND_DATA);
        put_result(Utf8Cont | {2'b00, cp[11:6]}, KIND_DATA);
      end else begin
        // lead byte keeps only the low 8 bits of the shifted value
        put_result(Utf8Lead4 | cp[25:18], KIND_DATA);
        put_result(Utf8Cont | {2'b00, cp[17:12]}, KIND_DATA);
        put_result(Utf8Cont | {2'b00, cp[11:6]}, KIND_DATA);
      end
      put_result(Utf8Cont | {2'b00, cp[5:0]}, KIND_DATA);
    end
  endtask

  // Emit what an open escape holds, then drop back to the plain body state.
  task automatic flush_escape();
    case (st)
      ST_HEX:  put_result((digits_rem != 0) ? acc[7:0] : (xup ? ChUpperX : ChLowerX),
                          KIND_DATA);
      ST_OCT:  put_result(acc[7:0], KIND_DATA);
      ST_UNI:  put_utf8(acc);
      default: ;
    endcase
    clear_lit_state();
  endtask

  task automatic plain_char(logic [7:0] c);
    if (c == ChQuote) begin
      put_result(8'h00, KIND_CLOSE);
      clear_lit_state();
    end else if (c == ChNewline) begin
      put_result(8'h00, KIND_ERROR);
      clear_lit_state();
    end else if (c == ChBslash) begin
      st = ST_ESC;
    end else begin
      put_result(c, KIND_DATA);
    end
  endtask

  task automatic escape_char(logic [7:0] c);
    clear_lit_state();
    case (c)
      "n": put_result(8'h0A, KIND_DATA);
      "t": put_result(8'h09, KIND_DATA);
      "r": put_result(8'h0D, KIND_DATA);
      "a": put_result(8'h07, KIND_DATA);
      "b": put_result(8'h08, KIND_DATA);
      "f": put_result(8'h0C, KIND_DATA);
      "v": put_result(8'h0B, KIND_DATA);
      default: begin
        if (c == ChLowerX || c == ChUpperX) begin
          st  = ST_HEX;
          xup = (c == ChUpperX);
        end else if (c == ChLowerU || c == ChUpperU) begin
          st         = ST_UNI;
          digits_rem = (c == ChLowerU) ? 4'd4 : 4'd8;
        end else if (c >= "0" && c <= "7") begin
          st         = ST_OCT;
          acc        = {29'd0, c[2:0]};
          digits_rem = 4'd2;
        end else begin
          put_result(c, KIND_DATA);
        end
      end
    endcase
  endtask

  task automatic decode_source_byte(logic [7:0] c, logic eos);
    int d;
    step_q.delete();
    d = hex_digit(c);
    if (eos) begin
      if (st != ST_ESC) flush_escape();
      put_result(8'h00, KIND_ERROR);
      clear_lit_state();
    end else begin
      case (st)
        ST_ESC: escape_char(c);
        ST_HEX: begin
          if (d >= 0) begin
            acc        = {acc[27:0], 4'(d)};
            digits_rem = 4'd1;
          end else begin
            flush_escape();
            plain_char(c);
          end
        end
        ST_OCT: begin
          if (c >= "0" && c <= "7" && digits_rem != 0) begin
            acc        = {acc[28:0], c[2:0]};
            digits_rem = digits_rem - 4'd1;
            if (digits_rem == 0) flush_escape();
          end else begin
            flush_escape();
            plain_char(c);
          end
        end
        ST_UNI: begin
          if (d >= 0 && digits_rem != 0) begin
            acc        = {acc[27:0], 4'(d)};
            digits_rem = digits_rem - 4'd1;
            if (digits_rem == 0) flush_escape();
          end else begin
            flush_escape();
            plain_char(c);
          end
        end
        default: begin
          clear_lit_state();
          plain_char(c);
        end
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    decoded_q = {decoded_q, step_q};
    outstanding += step_q.size();
  endtask

  task automatic note_mismatch(string what);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s: expected data %02h kind %0d last %0b, got data %02h kind %0d last %0b",
               $realtime, what, want.data, want.kind, want.last,
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_lit_state();
      decoded_q.delete();
      outstanding = 0;
      fails       = 0;
      n_data      = 0;
      n_close     = 0;
      n_error     = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_source_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          want = '0;
          note_mismatch("unexpected result");
        end else begin
          want = decoded_q.pop_front();
          outstanding--;
          case (want.kind)
            KIND_CLOSE: n_close++;
            KIND_ERROR: n_error++;
            default:    n_data++;
          endcase
          if (m_axis_tdata !== want.data || m_axis_tuser !== want.kind ||
              m_axis_tlast !== want.last) begin
            note_mismatch("result mismatch");
          end
        end
      end
    end
  end

endmodule

FILE: verif/string_literal_unescape_utf8_core_tb.sv
// Top testbench for string_literal_unescape_utf8_core: drives source bytes,
// throttles the result side and gives the verdict.
// Depends on slud_pkg, the block itself and slud_result_checker.
module string_literal_unescape_utf8_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slud_pkg::*;

  localparam int          RandomItems = 310;
  localparam int          DrainGuard  = 100000;
  localparam int          TailCycles  = 32;
  // escape letters that map to control bytes, one per byte lane
  localparam logic [55:0] SimpleEsc   = "ntrabfv";

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] ch
  logic       s_axis_tuser  = 1'b0;    // [0] end_of_source
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] out_byte
  logic [1:0] m_axis_tuser;            // [1:0] kind
  logic       m_axis_tlast;

  int fail_count, pending, data_count, close_count, error_count;
  int sent;
  int next_pause;
  bit calm;    // high during the stretch where neither side idles
  bit stuck;   // set when the results never drained

  string_literal_unescape_utf8_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  slud_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .data_count_o  (data_count),
    .close_count_o (close_count),
    .error_count_o (error_count)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result side at random, 19 percent of the time, never during the calm stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 19);
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Valid stays high into
  // the next request unless a random idle cycle lowers it first.
  task automatic send_byte(input logic [7:0] c, input logic eos);
    while (!calm && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Drop valid and hold off until every predicted result has come out.
  task automatic wait_drained();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && guard < DrainGuard) begin
      guard++;
      @(posedge clk_i);
    end
    if (pending != 0) stuck = 1'b1;
  endtask

  // Hex digit of either case, with extra zeros so short code points come up too.
  function automatic logic [7:0] rand_hex_char();
    int v;
    logic [7:0] base;
    v    = ($urandom_range(99) < 30) ? 0 : $urandom_range(15);
    base = ($urandom_range(1) == 1) ? "A" : "a";
    if (v < 10) return 8'(v) + "0";
    return 8'(v - 10) + base;
  endfunction

  // One well-formed piece of a literal body with random content, or some noise.
  task automatic send_token();
    int n;
    logic [7:0] c;
    case ($urandom_range(11))
      0, 1, 2: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == ChQuote || c == ChBslash) c = "a";
          send_byte(c, 1'b0);
        end
      end
      3: send_byte(8'($urandom), 1'b0);
      4: begin
        send_byte(ChBslash, 1'b0);
        send_byte(SimpleEsc[8 * $urandom_range(6) +: 8], 1'b0);
      end
      5: begin
        send_byte(ChBslash, 1'b0);
        send_byte(($urandom_range(1) == 1) ? ChUpperX : ChLowerX, 1'b0);
        n = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
        repeat (n) send_byte(rand_hex_char(), 1'b0);
      end
      6: begin
        send_byte(ChBslash, 1'b0);
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(7)) + "0", 1'b0);
      end
      7, 8: begin
        send_byte(ChBslash, 1'b0);
        if ($urandom_range(1) == 1) begin
          send_byte(ChUpperU, 1'b0);
          n = $urandom_range(0, 9);
        end else begin
          send_byte(ChLowerU, 1'b0);
          n = $urandom_range(0, 5);
        end
        repeat (n) send_byte(rand_hex_char(), 1'b0);
      end
      9: begin
        send_byte(ChBslash, 1'b0);
        send_byte(8'($urandom), 1'b0);
      end
      10: send_byte(($urandom_range(3) == 0) ? ChNewline : ChQuote, 1'b0);
      default: begin
        // end of source, sometimes right after a lone backslash
        if ($urandom_range(1) == 1) send_byte(ChBslash, 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
    endcase
  endtask

  initial begin
    sent       = 0;
    calm       = 1'b0;
    stuck      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: byte extremes, then the escape corner cases.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\\x\"");       // bare lower x, then the closing quote
    send_text("\\XfFg");      // upper X opens hex, digits FF, g ends it
    send_text("\\\n");        // unknown escape: backslash newline gives a byte
    send_text("\\U1F600\n");  // 4-byte UTF-8 then an unterminated error
    send_byte(ChBslash, 1'b0);
    send_byte(8'($urandom), 1'b1);  // backslash at end of source: error only
    send_text("\\777");       // longest octal escape

    // Pause once with everything drained before the random part.
    wait_drained();

    // Random part: a calm stretch in the middle, one more full drain later on.
    next_pause = sent + 180;
    while (sent < 26 + RandomItems) begin
      calm = (sent >= 140 && sent < 220);
      if (sent >= next_pause) begin
        wait_drained();
        next_pause = 1 << 30;
      end
      send_token();
    end
    calm = 1'b0;

    wait_drained();
    // Give the block time to show any stray result.
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d source bytes covering plain, simple, hex, octal and universal escapes;",
             sent);
    $display("checked %0d data bytes, %0d closes and %0d unterminated errors, %0d mismatches.",
             data_count, close_count, error_count, fail_count);
    if (fail_count == 0 && !stuck && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
